// ----- hdl/p1305_pkg.sv -----
// ----------------------------------------------------------------------------
// p1305_pkg - shared types and constants of the poly1305 mac
// limb sizes, clamp masks, register indexes and the command and status
// groups passed between controller and datapath
// ----------------------------------------------------------------------------
package p1305_pkg;

	// radix 2^26 limb arithmetic
	localparam int NUM_LIMBS = 5;
	localparam int LIMB_W    = 26;
	localparam int ACC_W     = 27;
	localparam int H_W       = 28;
	localparam int COEF_W    = 29;
	localparam int PROD_W    = H_W + COEF_W;
	localparam int SUM_W     = 62;
	localparam int CARRY_W   = SUM_W - LIMB_W;
	localparam int FOLD_W    = CARRY_W + 4;
	localparam int VAL_W     = NUM_LIMBS * LIMB_W;

	// item and register widths
	localparam int WORD_W     = 64;
	localparam int BLOCK_W    = 2 * WORD_W;
	localparam int BLOCK_BYTES = BLOCK_W / 8;
	localparam int CNT_W      = 5;
	localparam int S_TDATA_W  = ((BLOCK_W + CNT_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = BLOCK_W;
	localparam int CFG_IDX_W  = 4;

	// multiply sequencer steps
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_DONE  = STEP_W'(NUM_LIMBS);

	localparam logic [H_W-1:0] LIMB_MASK = H_W'((64'd1 << LIMB_W) - 64'd1);
	localparam logic [H_W-1:0] PAD_FIVE  = H_W'(5);

	// r clamp, per the rfc
	localparam logic [WORD_W-1:0] CLAMP_LOW  = 64'h0fff_fffc_0fff_ffff;
	localparam logic [WORD_W-1:0] CLAMP_HIGH = 64'h0fff_fffc_0fff_fffc;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_R_LOW  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_R_HIGH = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_S_LOW  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_S_HIGH = CFG_IDX_W'(3);

	typedef struct packed {
		logic [BLOCK_W-1:0] r;
		logic [BLOCK_W-1:0] s;
	} key_t;

	typedef struct packed {
		logic              load;
		logic              mul;
		logic              sum;
		logic [STEP_W-1:0] mul_idx;
		logic [STEP_W-1:0] sum_idx;
		logic              fold;
		logic              fin1;
		logic              fin2;
		logic              fin3;
		logic              emit;
	} cmd_t;

	typedef struct packed {
		logic absorb_req;
		logic finish_req;
		logic out_busy;
	} status_t;

endpackage

// ----- hdl/p1305_cfg.sv -----
// ----------------------------------------------------------------------------
// p1305_cfg - key registers
// holds r and s as written, hands out r already clamped
// ----------------------------------------------------------------------------
module p1305_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [p1305_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [p1305_pkg::WORD_W-1:0]    cfg_data,
	output p1305_pkg::key_t                 key
);
	import p1305_pkg::*;

	logic [WORD_W-1:0] r_low_q;
	logic [WORD_W-1:0] r_high_q;
	logic [WORD_W-1:0] s_low_q;
	logic [WORD_W-1:0] s_high_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_low_q  <= '0;
			r_high_q <= '0;
			s_low_q  <= '0;
			s_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_R_LOW:  r_low_q  <= cfg_data;
				CFG_R_HIGH: r_high_q <= cfg_data;
				CFG_S_LOW:  s_low_q  <= cfg_data;
				CFG_S_HIGH: s_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key.r = {r_high_q & CLAMP_HIGH, r_low_q & CLAMP_LOW};
	assign key.s = {s_high_q, s_low_q};

endmodule

// ----- hdl/p1305_ctrl.sv -----
// ----------------------------------------------------------------------------
// p1305_ctrl - sequencer of the poly1305 mac
// steps the datapath through absorb, fold and final reduction
// ----------------------------------------------------------------------------
module p1305_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  p1305_pkg::status_t  status,
	output p1305_pkg::cmd_t     cmd
);
	import p1305_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_FOLD = 7'b0000100,
		ST_FIN1 = 7'b0001000,
		ST_FIN2 = 7'b0010000,
		ST_FIN3 = 7'b0100000,
		ST_FIN4 = 7'b1000000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] cnt_q;
	logic [STEP_W-1:0] cnt_d;
	logic              fin_pend_q;
	logic              fin_pend_d;
	logic              accept;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		fin_pend_d = fin_pend_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					fin_pend_d = status.finish_req;
					if (status.absorb_req) begin
						cmd.load = 1'b1;
						cnt_d    = STEP_FIRST;
						state_d  = ST_MUL;
					end else begin
						state_d = ST_FIN1;
					end
				end
			end
			ST_MUL: begin
				// products for limb k are registered, then summed into limb k on the next step
				cmd.mul     = (cnt_q != STEP_DONE);
				cmd.sum     = (cnt_q != STEP_FIRST);
				cmd.mul_idx = cnt_q;
				cmd.sum_idx = cnt_q - STEP_W'(1);
				if (cnt_q == STEP_DONE) begin
					state_d = ST_FOLD;
				end else begin
					cnt_d = cnt_q + STEP_W'(1);
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = fin_pend_q ? ST_FIN1 : ST_IDLE;
			end
			ST_FIN1: begin
				cmd.fin1 = 1'b1;
				state_d  = ST_FIN2;
			end
			ST_FIN2: begin
				cmd.fin2 = 1'b1;
				state_d  = ST_FIN3;
			end
			ST_FIN3: begin
				cmd.fin3 = 1'b1;
				state_d  = ST_FIN4;
			end
			ST_FIN4: begin
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= STEP_FIRST;
			fin_pend_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			fin_pend_q <= fin_pend_d;
		end
	end

	a_load_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_MUL) && (cnt_q == STEP_FIRST))
		else $error("load did not start the multiply sweep");

	a_mul_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (cnt_q <= STEP_DONE))
		else $error("multiply step counter out of range");

	a_tag_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN4 && status.out_busy) |=> (state_q == ST_FIN4))
		else $error("tag dropped while output register held");

	a_fold_to_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD && fin_pend_q) |=> (state_q == ST_FIN1))
		else $error("message end lost after fold");

endmodule

// ----- hdl/p1305_dp.sv -----
// ----------------------------------------------------------------------------
// p1305_dp - datapath of the poly1305 mac
// block padding, five shared limb multipliers, carry sum, final reduction
// and the output register
// ----------------------------------------------------------------------------
module p1305_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [p1305_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [p1305_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input  p1305_pkg::key_t                 key,
	input  p1305_pkg::cmd_t                 cmd,
	output p1305_pkg::status_t              status
);
	import p1305_pkg::*;

	localparam int NB_W = CNT_W - 1;

	logic [ACC_W-1:0]  acc_q   [NUM_LIMBS];
	logic [H_W-1:0]    h_q     [NUM_LIMBS];
	logic [LIMB_W-1:0] rl_q    [NUM_LIMBS];
	logic [COEF_W-1:0] r5_q    [NUM_LIMBS];
	logic [PROD_W-1:0] prod_q  [NUM_LIMBS];
	logic [PROD_W-1:0] prod_d  [NUM_LIMBS];
	logic [H_W-1:0]    f_q     [NUM_LIMBS];
	logic [H_W-1:0]    fin1_d  [NUM_LIMBS];
	logic [H_W-1:0]    fin2_d  [NUM_LIMBS];
	logic [H_W-1:0]    fin3_d  [NUM_LIMBS];
	logic [LIMB_W-1:0] mlimb   [NUM_LIMBS];
	logic [LIMB_W-1:0] rlimb   [NUM_LIMBS];
	logic [CARRY_W-1:0] carry_q;
	logic [SUM_W-1:0]  sum_d;
	logic [FOLD_W-1:0] fold_t;
	logic [CNT_W-1:0]  count;
	logic [NB_W-1:0]   nbytes;
	logic              full;
	logic [BLOCK_W-1:0] blk;
	logic [BLOCK_W-1:0] msg;
	logic [VAL_W-1:0]  msg_val;
	logic [VAL_W-1:0]  r_val;
	logic [VAL_W-1:0]  f_val;
	logic [M_TDATA_W-1:0] tag_q;
	logic              out_valid_q;

	// item decode and padding
	assign blk    = s_axis_tdata[BLOCK_W-1:0];
	assign count  = s_axis_tdata[BLOCK_W +: CNT_W];
	assign full   = count[CNT_W-1];
	assign nbytes = count[NB_W-1:0];

	always_comb begin
		for (int b = 0; b < BLOCK_BYTES; b++) begin
			if (full || (NB_W'(b) < nbytes)) begin
				msg[8*b +: 8] = blk[8*b +: 8];
			end else if (NB_W'(b) == nbytes) begin
				msg[8*b +: 8] = 8'h01;
			end else begin
				msg[8*b +: 8] = 8'h00;
			end
		end
	end

	// full blocks carry the 2^128 bit
	assign msg_val = {{(VAL_W - BLOCK_W - 1){1'b0}}, full, msg};
	assign r_val   = {{(VAL_W - BLOCK_W){1'b0}}, key.r};

	always_comb begin
		for (int i = 0; i < NUM_LIMBS; i++) begin
			mlimb[i] = msg_val[LIMB_W*i +: LIMB_W];
			rlimb[i] = r_val[LIMB_W*i +: LIMB_W];
		end
	end

	assign status.absorb_req = (count != '0);
	assign status.finish_req = s_axis_tlast || !full;
	assign status.out_busy   = out_valid_q && !m_axis_tready;

	// shared multipliers: limb k of the product takes h[m] * r[k-m],
	// wrapping terms use 5*r
	always_comb begin
		logic [STEP_W:0]   t;
		logic [STEP_W:0]   ix;
		logic [COEF_W-1:0] coef;
		for (int m = 0; m < NUM_LIMBS; m++) begin
			t  = {1'b0, cmd.mul_idx} + (STEP_W + 1)'(NUM_LIMBS - m);
			ix = (t >= (STEP_W + 1)'(NUM_LIMBS)) ? t - (STEP_W + 1)'(NUM_LIMBS) : t;
			if (STEP_W'(m) > cmd.mul_idx) begin
				coef = r5_q[ix[STEP_W-1:0]];
			end else begin
				coef = COEF_W'(rl_q[ix[STEP_W-1:0]]);
			end
			prod_d[m] = PROD_W'(h_q[m]) * PROD_W'(coef);
		end
	end

	always_comb begin
		sum_d = (cmd.sum_idx == STEP_FIRST) ? '0 : SUM_W'(carry_q);
		for (int m = 0; m < NUM_LIMBS; m++) begin
			sum_d = sum_d + SUM_W'(prod_q[m]);
		end
	end

	// top carry folds back as times five
	assign fold_t = FOLD_W'(acc_q[0]) + (FOLD_W'(carry_q) << 2) + FOLD_W'(carry_q);

	// final reduction, first carry pass
	always_comb begin
		for (int i = 0; i < NUM_LIMBS; i++) begin
			fin1_d[i] = H_W'(acc_q[i]);
		end
		for (int i = 1; i < NUM_LIMBS; i++) begin
			fin1_d[(i + 1) % NUM_LIMBS] = fin1_d[(i + 1) % NUM_LIMBS] +
				((i == NUM_LIMBS - 1) ? ((fin1_d[i] >> LIMB_W) << 2) + (fin1_d[i] >> LIMB_W)
				                      : (fin1_d[i] >> LIMB_W));
			fin1_d[i] = fin1_d[i] & LIMB_MASK;
		end
		fin1_d[1] = fin1_d[1] + (fin1_d[0] >> LIMB_W);
		fin1_d[0] = fin1_d[0] & LIMB_MASK;
	end

	// h + 5 - 2^130, kept when not negative
	always_comb begin
		logic [H_W-1:0] g [NUM_LIMBS];
		g[0] = f_q[0] + PAD_FIVE;
		for (int i = 1; i < NUM_LIMBS; i++) begin
			g[i]     = f_q[i] + (g[i-1] >> LIMB_W);
			g[i-1]   = g[i-1] & LIMB_MASK;
		end
		for (int i = 0; i < NUM_LIMBS; i++) begin
			if ((g[NUM_LIMBS-1] >> LIMB_W) != '0) begin
				fin2_d[i] = g[i] & LIMB_MASK;
			end else begin
				fin2_d[i] = f_q[i];
			end
		end
	end

	// normalize before packing
	always_comb begin
		for (int i = 0; i < NUM_LIMBS; i++) begin
			fin3_d[i] = f_q[i];
		end
		for (int i = 1; i < NUM_LIMBS - 1; i++) begin
			fin3_d[i+1] = fin3_d[i+1] + (fin3_d[i] >> LIMB_W);
			fin3_d[i]   = fin3_d[i] & LIMB_MASK;
		end
		fin3_d[NUM_LIMBS-1] = fin3_d[NUM_LIMBS-1] & LIMB_MASK;
	end

	always_comb begin
		for (int i = 0; i < NUM_LIMBS; i++) begin
			f_val[LIMB_W*i +: LIMB_W] = f_q[i][LIMB_W-1:0];
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < NUM_LIMBS; i++) begin
				h_q[i]  <= H_W'(acc_q[i]) + H_W'(mlimb[i]);
				rl_q[i] <= rlimb[i];
				r5_q[i] <= (COEF_W'(rlimb[i]) << 2) + COEF_W'(rlimb[i]);
			end
		end
		if (cmd.mul) begin
			for (int m = 0; m < NUM_LIMBS; m++) begin
				prod_q[m] <= prod_d[m];
			end
		end
		if (cmd.sum) begin
			carry_q <= sum_d[SUM_W-1:LIMB_W];
		end
		if (cmd.fin1) begin
			f_q <= fin1_d;
		end else if (cmd.fin2) begin
			f_q <= fin2_d;
		end else if (cmd.fin3) begin
			f_q <= fin3_d;
		end
		if (cmd.emit) begin
			tag_q <= f_val[BLOCK_W-1:0] + key.s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LIMBS; i++) begin
				acc_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				for (int i = 0; i < NUM_LIMBS; i++) begin
					acc_q[i] <= '0;
				end
			end else if (cmd.sum) begin
				acc_q[cmd.sum_idx] <= ACC_W'(sum_d[LIMB_W-1:0]);
			end else if (cmd.fold) begin
				acc_q[0] <= ACC_W'(fold_t[LIMB_W-1:0]);
				acc_q[1] <= acc_q[1] + ACC_W'(fold_t[FOLD_W-1:LIMB_W]);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = tag_q;

	a_emit_shows_tag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_axis_tvalid)
		else $error("tag not presented after emit");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (acc_q[0] == '0) && (acc_q[NUM_LIMBS-1] == '0))
		else $error("accumulator not cleared at message end");

endmodule

// ----- hdl/poly1305_mac.sv -----
// ----------------------------------------------------------------------------
// poly1305_mac - poly1305 one-time authenticator, one 16-byte block per beat
// key registers, block absorb into the 130-bit accumulator and tag output
// ----------------------------------------------------------------------------
// Write r (clamped inside) and s through the cfg port while the block is
// idle, then stream message blocks, one 16-byte block per beat with its
// byte count. A full block (16 bytes) is absorbed with the 2^128 bit; a
// shorter block is padded with a 0x01 byte and always ends the message,
// as does tlast; a zero byte count only finalizes. At each message end one
// tag beat comes out and the accumulator clears for the next message; the
// key stays. An absorbed block steps through accept, five multiply
// steps with the carry sum one step behind, and fold of the top carry;
// the five shared 28x29 limb multipliers produce one result limb per
// cycle against the accumulator feedback. A message end adds the final
// reduction and s addition, whose emit waits while the previous tag
// still sits unread in the output register. A new item is accepted only
// while idle, never while one is in flight; the next item is accepted as
// soon as the tag is in the output register.
// ----------------------------------------------------------------------------
module poly1305_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	// block stream in
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [p1305_pkg::S_TDATA_W-1:0] s_axis_tdata,  // block_low, block_high,
	                                                       // byte_count, zero fill
	input  logic                            s_axis_tlast,  // last
	// tag stream out
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [p1305_pkg::M_TDATA_W-1:0] m_axis_tdata,  // tag_low, tag_high
	// key register writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [p1305_pkg::CFG_IDX_W-1:0] cfg_index,     // r_low, r_high, s_low, s_high
	input  logic [p1305_pkg::WORD_W-1:0]    cfg_data
);
	import p1305_pkg::*;

	key_t    key;     // clamped r and s
	cmd_t    cmd;     // controller to datapath
	status_t status;  // item decode and output backpressure

	// key registers; the user writes them only between messages, the block itself does not enforce it
	p1305_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key)
	);

	// sequencer: accept, multiply sweep, fold, final reduction, emit
	p1305_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.status        (status),
		.cmd           (cmd)
	);

	// accumulator, multipliers, reduction and the tag register
	p1305_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.key           (key),
		.cmd           (cmd),
		.status        (status)
	);

endmodule
